@@ hdl/kau_pkg.sv @@
// Shared types, widths and codes for the k-means assign/update block.
package kau_pkg;

	localparam int COORD_W = 16;
	localparam int FRAC_W  = 8;
	localparam int CENT_W  = COORD_W + FRAC_W;
	localparam int ID_W    = 4;
	localparam int OP_W    = 2;

	localparam int NUM_CLUSTERS_DEF    = 4;
	localparam int MAX_POINTS_LOG2_DEF = 20;

	localparam logic [OP_W-1:0] OP_POINT  = 2'd0;
	localparam logic [OP_W-1:0] OP_UPDATE = 2'd1;
	localparam logic [OP_W-1:0] OP_LOAD   = 2'd2;

	localparam logic KIND_POINT  = 1'b0;
	localparam logic KIND_REPORT = 1'b1;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_DIST_X,
		ST_DIST_Y,
		ST_DIST_CMP,
		ST_PT_OUT,
		ST_UPD_START,
		ST_DIV_X,
		ST_DIV_Y,
		ST_UPD_OUT
	} state_t;

endpackage

@@ hdl/kau_in_if.sv @@
// Input request channel: point, update or centroid load.
interface kau_in_if;
	logic                                valid;
	logic                                ready;
	logic [kau_pkg::OP_W-1:0]            op;
	logic signed [kau_pkg::COORD_W-1:0]  x;
	logic signed [kau_pkg::COORD_W-1:0]  y;
	logic [kau_pkg::ID_W-1:0]            index;

	modport source(output valid, op, x, y, index, input ready);
	modport sink(input valid, op, x, y, index, output ready);
endinterface

@@ hdl/kau_out_if.sv @@
// Result channel: point assignment or centroid report.
interface kau_out_if;
	logic                               valid;
	logic                               ready;
	logic                               kind;
	logic [kau_pkg::ID_W-1:0]           cluster_idx;
	logic signed [kau_pkg::CENT_W-1:0]  centroid_x;
	logic signed [kau_pkg::CENT_W-1:0]  centroid_y;
	logic                               moved;
	logic                               any_moved;
	logic                               last;

	modport source(output valid, kind, cluster_idx, centroid_x, centroid_y, moved, any_moved,
		last, input ready);
	modport sink(input valid, kind, cluster_idx, centroid_x, centroid_y, moved, any_moved,
		last, output ready);
endinterface

@@ hdl/kmeans_assign_update_top.sv @@
// Top level: 2-D k-means assignment and centroid update around one multiplier and one divider.
// Point request: three steps per centroid through one shared squarer, then the result is
// registered and the block returns to idle, waiting first while the result slot is full. A load
// is written when taken in idle. Update: per cluster, an empty one skips the bit-serial divider (x then y).
// One request is in flight at a time; a new one is taken while the last result waits.
// Reset (arst_n low) clears centroids, sums, counts and all control state at once.
module kmeans_assign_update_top #(
	parameter int NUM_CLUSTERS    = kau_pkg::NUM_CLUSTERS_DEF,
	parameter int MAX_POINTS_LOG2 = kau_pkg::MAX_POINTS_LOG2_DEF
) (
	input  logic       clk,
	input  logic       arst_n,
	kau_in_if.sink     item,
	kau_out_if.source  result
);

	localparam int COORD_W = kau_pkg::COORD_W;
	localparam int FRAC_W  = kau_pkg::FRAC_W;
	localparam int CENT_W  = kau_pkg::CENT_W;
	localparam int ID_W    = kau_pkg::ID_W;
	localparam int IW      = (NUM_CLUSTERS > 1) ? $clog2(NUM_CLUSTERS) : 1;
	localparam int SW      = COORD_W + MAX_POINTS_LOG2;
	localparam int CW      = MAX_POINTS_LOG2 + 1;
	localparam int DW      = SW + FRAC_W;
	localparam int BW      = $clog2(DW);
	localparam int DFW     = CENT_W + 1;
	localparam int PW      = 2 * DFW - 1;
	localparam int SQW     = PW + 1;

	kau_pkg::state_t state_q, state_d;

	logic signed [CENT_W-1:0] cx_mem [NUM_CLUSTERS];
	logic signed [CENT_W-1:0] cy_mem [NUM_CLUSTERS];
	logic signed [SW-1:0]     sx_mem [NUM_CLUSTERS];
	logic signed [SW-1:0]     sy_mem [NUM_CLUSTERS];
	logic [CW-1:0]            cnt_mem [NUM_CLUSTERS];

	logic signed [COORD_W-1:0] px_q, py_q;
	logic [IW-1:0]             clu_q, best_q;
	logic [SQW-1:0]            best_d_q;
	logic [PW-1:0]             prod_q, dsq_q;
	logic [CW-1:0]             rem_q;
	logic [CENT_W-1:0]         quo_q;
	logic [DW-1:0]             dvd_q;
	logic [BW-1:0]             bcnt_q;
	logic signed [CENT_W-1:0]  nx_q, ny_q;
	logic                      any_q;

	logic                      out_valid_q;
	logic                      kind_q, moved_q, any_moved_q, last_q;
	logic [ID_W-1:0]           cluster_idx_q;
	logic signed [CENT_W-1:0]  cent_x_q, cent_y_q;

	logic in_ready, out_load, out_free;

	// reads of the per-cluster stores, all at the one working index
	logic signed [CENT_W-1:0] cx_rd, cy_rd;
	logic signed [SW-1:0]     sx_rd, sy_rd;
	logic [CW-1:0]            cnt_rd;

	assign cx_rd  = cx_mem[clu_q];
	assign cy_rd  = cy_mem[clu_q];
	assign sx_rd  = sx_mem[clu_q];
	assign sy_rd  = sy_mem[clu_q];
	assign cnt_rd = cnt_mem[clu_q];

	logic clu_last, bcnt_last, item_acc, load_ok;
	assign clu_last  = (clu_q == IW'(NUM_CLUSTERS - 1));
	assign bcnt_last = (bcnt_q == BW'(DW - 1));
	assign item_acc  = item.valid && in_ready;
	assign load_ok   = ({1'b0, item.index} < (ID_W + 1)'(NUM_CLUSTERS));

	// distance: one shared squarer
	logic signed [CENT_W-1:0] px_fx, py_fx;
	logic signed [DFW-1:0]    dx, dy, mul_a;
	logic signed [2*DFW-1:0]  prod_full;
	logic [SQW-1:0]           d_sum;
	logic                     take_best;

	assign px_fx     = {px_q, {FRAC_W{1'b0}}};
	assign py_fx     = {py_q, {FRAC_W{1'b0}}};
	assign dx        = {px_fx[CENT_W-1], px_fx} - {cx_rd[CENT_W-1], cx_rd};
	assign dy        = {py_fx[CENT_W-1], py_fx} - {cy_rd[CENT_W-1], cy_rd};
	assign mul_a     = (state_q == kau_pkg::ST_DIST_Y) ? dy : dx;
	assign prod_full = mul_a * mul_a;
	assign d_sum     = {1'b0, dsq_q} + {1'b0, prod_q};
	assign take_best = (clu_q == '0) || (d_sum < best_d_q);

	// accumulate
	logic signed [SW-1:0] sx_add, sy_add;
	assign sx_add = sx_rd + {{(SW - COORD_W){px_q[COORD_W-1]}}, px_q};
	assign sy_add = sy_rd + {{(SW - COORD_W){py_q[COORD_W-1]}}, py_q};

	// bit-serial divider on magnitudes, sign applied at the end
	logic [SW-1:0]     sx_abs, sy_abs;
	logic [CW-1:0]     r2, r_next;
	logic              ge, div_neg;
	logic [CENT_W-1:0] q_next;
	logic signed [CENT_W-1:0] q_res;

	assign sx_abs  = sx_rd[SW-1] ? SW'(-sx_rd) : SW'(sx_rd);
	assign sy_abs  = sy_rd[SW-1] ? SW'(-sy_rd) : SW'(sy_rd);
	assign r2      = {rem_q[CW-2:0], dvd_q[DW-1]};
	assign ge      = (r2 >= cnt_rd);
	assign r_next  = ge ? (r2 - cnt_rd) : r2;
	assign q_next  = {quo_q[CENT_W-2:0], ge};
	assign div_neg = (state_q == kau_pkg::ST_DIV_Y) ? sy_rd[SW-1] : sx_rd[SW-1];
	assign q_res   = div_neg ? CENT_W'(-q_next) : CENT_W'(q_next);

	// update report
	logic                     nonempty, upd_moved;
	logic signed [CENT_W-1:0] upd_x, upd_y;
	assign nonempty  = (cnt_rd != '0);
	assign upd_moved = nonempty && ((nx_q != cx_rd) || (ny_q != cy_rd));
	assign upd_x     = nonempty ? nx_q : cx_rd;
	assign upd_y     = nonempty ? ny_q : cy_rd;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= kau_pkg::ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d  = state_q;
		in_ready = 1'b0;
		out_load = 1'b0;
		out_free = !out_valid_q || result.ready;
		case (state_q)
			kau_pkg::ST_IDLE: begin
				in_ready = 1'b1;
				if (item.valid && item.op == kau_pkg::OP_POINT) begin
					state_d = kau_pkg::ST_DIST_X;
				end else if (item.valid && item.op == kau_pkg::OP_UPDATE) begin
					state_d = kau_pkg::ST_UPD_START;
				end
			end
			kau_pkg::ST_DIST_X: state_d = kau_pkg::ST_DIST_Y;
			kau_pkg::ST_DIST_Y: state_d = kau_pkg::ST_DIST_CMP;
			kau_pkg::ST_DIST_CMP: begin
				state_d = clu_last ? kau_pkg::ST_PT_OUT : kau_pkg::ST_DIST_X;
			end
			kau_pkg::ST_PT_OUT: begin
				if (out_free) begin
					out_load = 1'b1;
					state_d  = kau_pkg::ST_IDLE;
				end
			end
			kau_pkg::ST_UPD_START: begin
				state_d = nonempty ? kau_pkg::ST_DIV_X : kau_pkg::ST_UPD_OUT;
			end
			kau_pkg::ST_DIV_X: begin
				if (bcnt_last) state_d = kau_pkg::ST_DIV_Y;
			end
			kau_pkg::ST_DIV_Y: begin
				if (bcnt_last) state_d = kau_pkg::ST_UPD_OUT;
			end
			kau_pkg::ST_UPD_OUT: begin
				if (out_free) begin
					out_load = 1'b1;
					state_d  = clu_last ? kau_pkg::ST_IDLE : kau_pkg::ST_UPD_START;
				end
			end
			default: state_d = kau_pkg::ST_IDLE;
		endcase
	end

	// control and cluster stores
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < NUM_CLUSTERS; i++) begin
				cx_mem[i]  <= '0;
				cy_mem[i]  <= '0;
				sx_mem[i]  <= '0;
				sy_mem[i]  <= '0;
				cnt_mem[i] <= '0;
			end
			clu_q       <= '0;
			best_q      <= '0;
			bcnt_q      <= '0;
			any_q       <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (result.ready) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				kau_pkg::ST_IDLE: begin
					if (item_acc) begin
						clu_q <= '0;
						any_q <= 1'b0;
						if (item.op == kau_pkg::OP_LOAD && load_ok) begin
							cx_mem[item.index[IW-1:0]] <= {item.x, {FRAC_W{1'b0}}};
							cy_mem[item.index[IW-1:0]] <= {item.y, {FRAC_W{1'b0}}};
						end
					end
				end
				kau_pkg::ST_DIST_CMP: begin
					if (take_best) best_q <= clu_q;
					if (clu_last) begin
						clu_q <= take_best ? clu_q : best_q;
					end else begin
						clu_q <= clu_q + 1'b1;
					end
				end
				kau_pkg::ST_PT_OUT: begin
					// a full cluster still gets the point, but its sums stay put
					if (out_free && !cnt_rd[CW-1]) begin
						sx_mem[clu_q]  <= sx_add;
						sy_mem[clu_q]  <= sy_add;
						cnt_mem[clu_q] <= cnt_rd + 1'b1;
					end
				end
				kau_pkg::ST_UPD_START: begin
					bcnt_q <= '0;
				end
				kau_pkg::ST_DIV_X, kau_pkg::ST_DIV_Y: begin
					bcnt_q <= bcnt_last ? '0 : bcnt_q + 1'b1;
				end
				kau_pkg::ST_UPD_OUT: begin
					if (out_free) begin
						cx_mem[clu_q]  <= upd_x;
						cy_mem[clu_q]  <= upd_y;
						sx_mem[clu_q]  <= '0;
						sy_mem[clu_q]  <= '0;
						cnt_mem[clu_q] <= '0;
						any_q          <= any_q | upd_moved;
						if (!clu_last) clu_q <= clu_q + 1'b1;
					end
				end
				default: ;
			endcase
		end
	end

	// datapath and result payload
	always_ff @(posedge clk) begin
		case (state_q)
			kau_pkg::ST_IDLE: begin
				if (item_acc) begin
					px_q <= item.x;
					py_q <= item.y;
				end
			end
			kau_pkg::ST_DIST_X: begin
				prod_q <= prod_full[PW-1:0];
			end
			kau_pkg::ST_DIST_Y: begin
				dsq_q  <= prod_q;
				prod_q <= prod_full[PW-1:0];
			end
			kau_pkg::ST_DIST_CMP: begin
				if (take_best) best_d_q <= d_sum;
			end
			kau_pkg::ST_UPD_START: begin
				dvd_q <= {sx_abs, {FRAC_W{1'b0}}};
				rem_q <= '0;
				quo_q <= '0;
			end
			kau_pkg::ST_DIV_X: begin
				if (bcnt_last) begin
					nx_q  <= q_res;
					dvd_q <= {sy_abs, {FRAC_W{1'b0}}};
					rem_q <= '0;
					quo_q <= '0;
				end else begin
					dvd_q <= {dvd_q[DW-2:0], 1'b0};
					rem_q <= r_next;
					quo_q <= q_next;
				end
			end
			kau_pkg::ST_DIV_Y: begin
				if (bcnt_last) begin
					ny_q <= q_res;
				end else begin
					dvd_q <= {dvd_q[DW-2:0], 1'b0};
					rem_q <= r_next;
					quo_q <= q_next;
				end
			end
			default: ;
		endcase

		if (out_load) begin
			cluster_idx_q <= ID_W'(clu_q);
			if (state_q == kau_pkg::ST_PT_OUT) begin
				kind_q      <= kau_pkg::KIND_POINT;
				cent_x_q    <= cx_rd;
				cent_y_q    <= cy_rd;
				moved_q     <= 1'b0;
				any_moved_q <= 1'b0;
				last_q      <= 1'b1;
			end else begin
				kind_q      <= kau_pkg::KIND_REPORT;
				cent_x_q    <= upd_x;
				cent_y_q    <= upd_y;
				moved_q     <= upd_moved;
				any_moved_q <= any_q | upd_moved;
				last_q      <= clu_last;
			end
		end
	end

	assign item.ready         = in_ready;
	assign result.valid       = out_valid_q;
	assign result.kind        = kind_q;
	assign result.cluster_idx = cluster_idx_q;
	assign result.centroid_x  = cent_x_q;
	assign result.centroid_y  = cent_y_q;
	assign result.moved       = moved_q;
	assign result.any_moved   = any_moved_q;
	assign result.last        = last_q;

	a_point_flags: assert property (@(posedge clk) disable iff (!arst_n)
		result.valid && result.kind == kau_pkg::KIND_POINT
		|-> !result.moved && !result.any_moved && result.last)
		else $error("point result with report flags");

	a_moved_any: assert property (@(posedge clk) disable iff (!arst_n)
		result.valid && result.kind == kau_pkg::KIND_REPORT && result.moved
		|-> result.any_moved)
		else $error("moved centroid without any_moved");

	a_div_rem: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == kau_pkg::ST_DIV_X || state_q == kau_pkg::ST_DIV_Y)
		|-> (rem_q < cnt_rd))
		else $error("divider remainder not below divisor");

	a_cnt_bound: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_rd <= {1'b1, {MAX_POINTS_LOG2{1'b0}}})
		else $error("member count beyond limit");

endmodule

@@ tb/testbench.sv @@
// Self-checking testbench for kmeans_assign_update_top: point, update and load requests.
module testbench;

	localparam int COORD_W     = kau_pkg::COORD_W;
	localparam int CENT_W      = kau_pkg::CENT_W;
	localparam int ID_W        = kau_pkg::ID_W;
	localparam int OP_W        = kau_pkg::OP_W;
	localparam int NCL         = kau_pkg::NUM_CLUSTERS_DEF;
	localparam int PTS_LOG2    = kau_pkg::MAX_POINTS_LOG2_DEF;
	localparam int SUM_W       = COORD_W + PTS_LOG2;
	localparam int CNT_W       = PTS_LOG2 + 1;
	localparam int CYCLE_LIMIT = 400000;
	localparam int RANDOM_REQS = 290;
	localparam int MAX_REPORTS = 10;

	// op code 3 has no meaning in the block
	localparam logic [OP_W-1:0] OP_UNUSED = 2'd3;

	typedef struct packed {
		logic [OP_W-1:0]           op;
		logic signed [COORD_W-1:0] x;
		logic signed [COORD_W-1:0] y;
		logic [ID_W-1:0]           index;
	} request_t;

	typedef struct packed {
		logic                     kind;
		logic [ID_W-1:0]          cluster_idx;
		logic signed [CENT_W-1:0] centroid_x;
		logic signed [CENT_W-1:0] centroid_y;
		logic                     moved;
		logic                     any_moved;
		logic                     last;
	} report_t;

	class centroid_tracker;
		bit signed [CENT_W-1:0] cent_x[NCL];
		bit signed [CENT_W-1:0] cent_y[NCL];
		bit signed [SUM_W-1:0]  sum_x[NCL];
		bit signed [SUM_W-1:0]  sum_y[NCL];
		bit [CNT_W-1:0]         members[NCL];
		report_t                expected_reports[$];
		int mismatches;
		int unexpected;
		int checked;
		int points;
		int updates;
		int loads;
		int steady_updates;

		function new();
			for (int i = 0; i < NCL; i++) begin
				cent_x[i] = '0;
				cent_y[i] = '0;
				sum_x[i] = '0;
				sum_y[i] = '0;
				members[i] = '0;
			end
			mismatches = 0;
			unexpected = 0;
			checked = 0;
			points = 0;
			updates = 0;
			loads = 0;
			steady_updates = 0;
		endfunction

		function void note_request(request_t req);
			longint px, py, dx, dy, sq_dist, best_dist, nx, ny;
			int best;
			bit moved, any;
			report_t rep;
			px = longint'($signed(req.x));
			py = longint'($signed(req.y));
			best = 0;
			best_dist = 0;
			any = 1'b0;
			case (req.op)
			kau_pkg::OP_LOAD: begin
				if (req.index < NCL) begin
					cent_x[req.index] = CENT_W'(px * 256);
					cent_y[req.index] = CENT_W'(py * 256);
					loads++;
				end
			end
			kau_pkg::OP_POINT: begin
				for (int i = 0; i < NCL; i++) begin
					dx = px * 256 - longint'(cent_x[i]);
					dy = py * 256 - longint'(cent_y[i]);
					sq_dist = dx * dx + dy * dy;
					// strict compare: lowest index keeps a tie
					if (i == 0 || sq_dist < best_dist) begin
						best_dist = sq_dist;
						best = i;
					end
				end
				// a full cluster still takes the point but no longer accumulates it
				if (longint'(members[best]) < (longint'(1) << PTS_LOG2)) begin
					sum_x[best] = SUM_W'(longint'(sum_x[best]) + px);
					sum_y[best] = SUM_W'(longint'(sum_y[best]) + py);
					members[best] = members[best] + 1'b1;
				end
				rep.kind = kau_pkg::KIND_POINT;
				rep.cluster_idx = ID_W'(best);
				rep.centroid_x = cent_x[best];
				rep.centroid_y = cent_y[best];
				rep.moved = 1'b0;
				rep.any_moved = 1'b0;
				rep.last = 1'b1;
				expected_reports.push_back(rep);
				points++;
			end
			kau_pkg::OP_UPDATE: begin
				for (int i = 0; i < NCL; i++) begin
					moved = 1'b0;
					// empty cluster keeps its centroid
					if (members[i] != 0) begin
						nx = (longint'(sum_x[i]) * 256) / longint'(members[i]);
						ny = (longint'(sum_y[i]) * 256) / longint'(members[i]);
						if (nx != longint'(cent_x[i]) || ny != longint'(cent_y[i]))
							moved = 1'b1;
						cent_x[i] = CENT_W'(nx);
						cent_y[i] = CENT_W'(ny);
					end
					any = any | moved;
					sum_x[i] = '0;
					sum_y[i] = '0;
					members[i] = '0;
					rep.kind = kau_pkg::KIND_REPORT;
					rep.cluster_idx = ID_W'(i);
					rep.centroid_x = cent_x[i];
					rep.centroid_y = cent_y[i];
					rep.moved = moved;
					rep.any_moved = any;
					rep.last = (i == NCL - 1);
					expected_reports.push_back(rep);
				end
				updates++;
				if (!any)
					steady_updates++;
			end
			default: ;
			endcase
		endfunction

		function void check_result(report_t got, int cyc);
			report_t want;
			if (expected_reports.size() == 0) begin
				unexpected++;
				if (mismatches + unexpected <= MAX_REPORTS)
					$display("cycle %0d: result with nothing pending: kind=%0d id=%0d x=%0d y=%0d",
						cyc, got.kind, got.cluster_idx, got.centroid_x, got.centroid_y);
				return;
			end
			want = expected_reports.pop_front();
			checked++;
			if (got.kind !== want.kind || got.cluster_idx !== want.cluster_idx ||
					got.centroid_x !== want.centroid_x || got.centroid_y !== want.centroid_y ||
					got.moved !== want.moved || got.any_moved !== want.any_moved ||
					got.last !== want.last) begin
				mismatches++;
				if (mismatches + unexpected <= MAX_REPORTS) begin
					$display("cycle %0d: mismatch", cyc);
					$display("  expected kind=%0d id=%0d x=%0d y=%0d moved=%0d any=%0d last=%0d",
						want.kind, want.cluster_idx, want.centroid_x, want.centroid_y,
						want.moved, want.any_moved, want.last);
					$display("  actual   kind=%0d id=%0d x=%0d y=%0d moved=%0d any=%0d last=%0d",
						got.kind, got.cluster_idx, got.centroid_x, got.centroid_y,
						got.moved, got.any_moved, got.last);
				end
			end
		endfunction

		function int failures();
			return mismatches + unexpected + expected_reports.size();
		endfunction
	endclass

	logic clk = 1'b0;
	logic arst_n;
	bit   calm;
	int   cycles = 0;
	int   seed_x[NCL];
	int   seed_y[NCL];

	centroid_tracker tracker = new();

	kau_in_if  item_if();
	kau_out_if result_if();

	kmeans_assign_update_top #(
		.NUM_CLUSTERS(NCL),
		.MAX_POINTS_LOG2(PTS_LOG2)
	) uut (
		.clk(clk),
		.arst_n(arst_n),
		.item(item_if),
		.result(result_if)
	);

	always #1 clk = ~clk;

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles >= CYCLE_LIMIT) begin
			$display("timeout after %0d cycles", cycles);
			$display("[kmeans_assign_update_top] ERROR");
			$finish;
		end
	end

	function automatic int rand_coord();
		logic signed [COORD_W-1:0] v;
		v = COORD_W'($urandom());
		return int'(v);
	endfunction

	function automatic int clamp_coord(int v);
		if (v > 32767)
			return 32767;
		if (v < -32768)
			return -32768;
		return v;
	endfunction

	task automatic send_request(input logic [OP_W-1:0] op, input int x, input int y,
			input int idx);
		int gap;
		request_t req;
		gap = calm ? 0 : $urandom_range(0, 4);
		if (gap != 0) begin
			item_if.valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		req.op = op;
		req.x = COORD_W'(x);
		req.y = COORD_W'(y);
		req.index = ID_W'(idx);
		if (op == kau_pkg::OP_LOAD && idx < NCL) begin
			seed_x[idx] = x;
			seed_y[idx] = y;
		end
		item_if.op <= req.op;
		item_if.x <= req.x;
		item_if.y <= req.y;
		item_if.index <= req.index;
		item_if.valid <= 1'b1;
		do @(posedge clk); while (!item_if.ready);
		tracker.note_request(req);
		@(negedge clk);
	endtask

	task automatic hold_until_drained();
		item_if.valid <= 1'b0;
		do @(negedge clk); while (tracker.expected_reports.size() != 0);
	endtask

	// result side: random back-pressure per result
	initial begin : result_sink
		int stall;
		report_t got;
		@(posedge arst_n);
		@(negedge clk);
		forever begin
			stall = calm ? 0 : $urandom_range(0, 4);
			if (stall != 0) begin
				result_if.ready <= 1'b0;
				repeat (stall) @(negedge clk);
			end
			result_if.ready <= 1'b1;
			do @(posedge clk); while (!result_if.valid);
			got.kind = result_if.kind;
			got.cluster_idx = result_if.cluster_idx;
			got.centroid_x = result_if.centroid_x;
			got.centroid_y = result_if.centroid_y;
			got.moved = result_if.moved;
			got.any_moved = result_if.any_moved;
			got.last = result_if.last;
			tracker.check_result(got, cycles);
			@(negedge clk);
		end
	end

	initial begin : stimulus
		int counted, pass_no, npts, mode, c, spread, cx, cy;
		int pass_x[$];
		int pass_y[$];
		bit replay;
		item_if.valid = 1'b0;
		item_if.op = kau_pkg::OP_POINT;
		item_if.x = '0;
		item_if.y = '0;
		item_if.index = '0;
		result_if.ready = 1'b0;
		arst_n = 1'b0;
		calm = 1'b0;
		for (int i = 0; i < NCL; i++) begin
			seed_x[i] = 0;
			seed_y[i] = 0;
		end
		repeat (11) @(negedge clk);
		arst_n <= 1'b1;
		repeat (2) @(negedge clk);

		// all centroids at zero after reset: four-way tie goes to cluster 0
		send_request(kau_pkg::OP_POINT, 0, 0, 0);
		send_request(kau_pkg::OP_LOAD, -32768, -32768, 0);
		send_request(kau_pkg::OP_LOAD, 32767, 32767, 1);
		send_request(kau_pkg::OP_LOAD, -32768, 32767, 2);
		send_request(kau_pkg::OP_LOAD, 32767, -32768, 3);
		// loads past the last cluster and the unused op do nothing
		send_request(kau_pkg::OP_LOAD, 0, 0, NCL);
		send_request(kau_pkg::OP_LOAD, 5, 5, 15);
		send_request(OP_UNUSED, -1, -1, 15);
		send_request(kau_pkg::OP_POINT, -32768, -32768, 0);
		send_request(kau_pkg::OP_POINT, 32767, 32767, 0);
		send_request(kau_pkg::OP_POINT, -32768, 32767, 0);
		send_request(kau_pkg::OP_POINT, 32767, -32768, 0);
		send_request(kau_pkg::OP_POINT, 0, 0, 0);
		send_request(kau_pkg::OP_POINT, -1, 1, 0);
		send_request(kau_pkg::OP_UPDATE, 0, 0, 0);
		// nothing accumulated: every cluster empty, no movement
		send_request(kau_pkg::OP_UPDATE, 0, 0, 0);
		send_request(kau_pkg::OP_LOAD, 0, 0, 0);
		send_request(kau_pkg::OP_LOAD, 2, 0, 1);
		send_request(kau_pkg::OP_POINT, 1, 0, 0);
		send_request(kau_pkg::OP_POINT, 1, 1, 0);
		send_request(kau_pkg::OP_POINT, -1, 0, 0);
		send_request(kau_pkg::OP_POINT, -1, -1, 0);
		send_request(kau_pkg::OP_UPDATE, 0, 0, 0);
		hold_until_drained();

		counted = 0;
		pass_no = 0;
		while (counted < RANDOM_REQS) begin
			calm = ($urandom_range(0, 5) == 0);
			replay = (pass_x.size() != 0) && ($urandom_range(0, 9) < 3);
			if (!replay) begin
				pass_x.delete();
				pass_y.delete();
				if ($urandom_range(0, 2) != 0) begin
					for (int k = 0; k < NCL; k++) begin
						mode = $urandom_range(0, 3);
						case (mode)
						0: begin
							cx = rand_coord();
							cy = rand_coord();
						end
						3: begin
							cx = $urandom_range(0, 1) ? 32767 : -32768;
							cy = $urandom_range(0, 1) ? 32767 : -32768;
						end
						default: begin
							cx = $urandom_range(0, 6000) - 3000;
							cy = $urandom_range(0, 6000) - 3000;
						end
						endcase
						if ($urandom_range(0, 4) != 0) begin
							send_request(kau_pkg::OP_LOAD, cx, cy, k);
							counted++;
						end
					end
				end
				npts = $urandom_range(1, 12);
				for (int k = 0; k < npts; k++) begin
					if ($urandom_range(0, 3) == 0) begin
						pass_x.push_back(rand_coord());
						pass_y.push_back(rand_coord());
					end else begin
						c = $urandom_range(0, NCL - 1);
						spread = $urandom_range(0, 300);
						pass_x.push_back(clamp_coord(seed_x[c] +
							$urandom_range(0, 2 * spread) - spread));
						pass_y.push_back(clamp_coord(seed_y[c] +
							$urandom_range(0, 2 * spread) - spread));
					end
				end
			end
			foreach (pass_x[k]) begin
				if ($urandom_range(0, 9) == 0) begin
					if ($urandom_range(0, 1))
						send_request(OP_UNUSED, rand_coord(), rand_coord(),
							$urandom_range(0, 15));
					else
						send_request(kau_pkg::OP_LOAD, rand_coord(), rand_coord(),
							$urandom_range(NCL, 15));
					counted++;
				end
				send_request(kau_pkg::OP_POINT, pass_x[k], pass_y[k], $urandom_range(0, 15));
				counted++;
			end
			if ($urandom_range(0, 9) != 0) begin
				send_request(kau_pkg::OP_UPDATE, rand_coord(), rand_coord(),
					$urandom_range(0, 15));
				counted++;
			end
			pass_no++;
			if (pass_no % 7 == 0)
				hold_until_drained();
		end

		calm = 1'b0;
		item_if.valid <= 1'b0;
		while (tracker.expected_reports.size() != 0) @(negedge clk);
		repeat (64) @(negedge clk);

		$display("run covered %0d points, %0d updates and %0d centroid loads over %0d passes",
			tracker.points, tracker.updates, tracker.loads, pass_no);
		$display("%0d results checked; %0d updates left every centroid in place",
			tracker.checked, tracker.steady_updates);
		if (tracker.failures() == 0) begin
			$display("[kmeans_assign_update_top] OK");
		end else begin
			$display("%0d mismatches, %0d unexpected, %0d missing", tracker.mismatches,
				tracker.unexpected, tracker.expected_reports.size());
			$display("[kmeans_assign_update_top] ERROR");
		end
		$finish;
	end

endmodule
